// File: hdl/sqvt_pkg.sv
// Shared types, constants and helper functions for the sprite quad vertex transform.
// No dependencies; imported by every module of the block except sqvt_dly.
package sqvt_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_TEX_DIM_DEF   = 16'd4096;

  localparam int POS_W   = 24;
  localparam int UV_W    = 16;
  localparam int EDGE_W  = 14;
  localparam int DIM_W   = 13;
  localparam int TRIG_W  = 32;
  localparam int LOC_W   = 36;
  localparam int PROD_W  = LOC_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CX_W    = 34;
  localparam int DIV_LAT = 18;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic REG_TEX_W = 1'b0;
  localparam logic REG_TEX_H = 1'b1;

  typedef struct packed {
    logic signed [LOC_W-1:0]  lx0;
    logic signed [LOC_W-1:0]  lx1;
    logic signed [LOC_W-1:0]  ly0;
    logic signed [LOC_W-1:0]  ly1;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
    logic [UV_W-1:0]          u0;
    logic [UV_W-1:0]          u1;
    logic [UV_W-1:0]          v0;
    logic [UV_W-1:0]          v1;
  } sqvt_corner_in_t;

  function automatic logic signed [31:0] atan_val(input int i);
    logic signed [31:0] r;
    case (i)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41721;
      15: r = 32'sd20860;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2607;
      19: r = 32'sd1303;
      20: r = 32'sd651;
      21: r = 32'sd325;
      22: r = 32'sd162;
      23: r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [38:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 39'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -39'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/sprite_quad_vertex_transform.sv
// Sprite quad vertex transform: one sprite request in, four corner vertices out.
// Uses sqvt_pkg, sqvt_cordic, sqvt_div, sqvt_dly and sqvt_corner.
//
// Request channel: an item is taken on a clock edge with start high and busy low.
// busy then stays high while a down-counter runs out, so requests are paced to
// match the four-vertex output.
// Result channel: vertex_valid marks each vertex for exactly one cycle; the four
// vertices of a sprite come on consecutive cycles in order top-left, top-right,
// bottom-left, bottom-right, last_corner high on the fourth.
// The first vertex follows the taken request after the CORDIC pipeline or the
// 16-step texture divider, whichever is longer, plus the multiply/round stages.
// Output: one vertex per cycle.
// Configuration: APB, texture_width at 0x0, texture_height at 0x4. The user writes
// them only while idle; the block does not enforce it. Reset sets both to 256 and
// empties the pipeline.
// The receiver cannot stall; vertices are never held.
module sprite_quad_vertex_transform import sqvt_pkg::*; #(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int MAX_TEXTURE_DIM = MAX_TEX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [11:0]             src_left,
  input  logic [11:0]             src_top,
  input  logic [12:0]             src_width,
  input  logic [12:0]             src_height,
  input  logic signed [15:0]      scale_x,
  input  logic signed [15:0]      scale_y,
  input  logic [15:0]             angle,
  input  logic signed [15:0]      pivot_x,
  input  logic signed [15:0]      pivot_y,
  output logic                    vertex_valid,
  output logic [1:0]              corner_index,
  output logic signed [POS_W-1:0] vertex_x,
  output logic signed [POS_W-1:0] vertex_y,
  output logic [UV_W-1:0]         tex_u,
  output logic [UV_W-1:0]         tex_v,
  output logic                    last_corner
);

  localparam int CORD_LAT = CORDIC_STAGES + 2;
  localparam int ALIGN    = ((CORD_LAT > DIV_LAT) ? CORD_LAT : DIV_LAT) + 1;
  localparam int GEO_LAT  = 3;
  localparam int GEO_W    = 4 * LOC_W + 2 * POS_W;

  logic [DIM_W-1:0] texture_width, texture_height;
  logic [1:0] cnt, cnt_next;
  logic       accept;
  logic [ALIGN-1:0] vsh;

  // geometry stages
  logic signed [POS_W-1:0] px1, py1, px2, py2, px3, py3;
  logic signed [15:0]      sx1, sy1, hx1, hy1;
  logic [12:0]             w1, h1;
  logic signed [LOC_W-1:0] cx2, cy2, wx2, hy22;
  logic signed [LOC_W-1:0] lx0, lx1, ly0, ly1;
  logic [GEO_W-1:0]        geo_q;

  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic [2*TRIG_W-1:0]      trig_q;
  logic [UV_W-1:0]          u0, u1, v0, v1;
  logic [4*UV_W-1:0]        uv_q;

  sqvt_corner_in_t cin;

  assign pready = 1'b1;
  assign accept = start && !busy;
  assign busy   = (cnt != 2'd0);

  always_comb begin
    cnt_next = cnt;
    if (accept) begin
      cnt_next = 2'd3;
    end else if (cnt != 2'd0) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      vsh <= '0;
      texture_width  <= 13'd256;
      texture_height <= 13'd256;
    end else begin
      cnt <= cnt_next;
      vsh <= {vsh[ALIGN-2:0], accept};
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_TEX_W: texture_width  <= pwdata[DIM_W-1:0];
          REG_TEX_H: texture_height <= pwdata[DIM_W-1:0];
          default:   texture_width  <= texture_width;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TEX_W: prdata = {19'b0, texture_width};
      REG_TEX_H: prdata = {19'b0, texture_height};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    px1  <= pos_x;
    py1  <= pos_y;
    sx1  <= scale_x;
    sy1  <= scale_y;
    hx1  <= pivot_x;
    hy1  <= pivot_y;
    w1   <= src_width;
    h1   <= src_height;

    px2  <= px1;
    py2  <= py1;
    cx2  <= -(LOC_W'(hx1) * LOC_W'(sx1));
    cy2  <= -(LOC_W'(hy1) * LOC_W'(sy1));
    wx2  <= (LOC_W'($signed({1'b0, w1})) * LOC_W'(sx1)) <<< 4;
    hy22 <= (LOC_W'($signed({1'b0, h1})) * LOC_W'(sy1)) <<< 4;

    px3  <= px2;
    py3  <= py2;
    lx0  <= cx2;
    lx1  <= cx2 + wx2;
    ly0  <= cy2;
    ly1  <= cy2 + hy22;
  end

  sqvt_dly #(.W(GEO_W), .DEPTH(ALIGN - GEO_LAT)) u_geo_dly (
    .clk (clk),
    .d   ({lx0, lx1, ly0, ly1, px3, py3}),
    .q   (geo_q)
  );

  sqvt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .angle (angle),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  sqvt_dly #(.W(2 * TRIG_W), .DEPTH(ALIGN - CORD_LAT)) u_trig_dly (
    .clk (clk),
    .d   ({cos_q, sin_q}),
    .q   (trig_q)
  );

  sqvt_div #(.MAX_DIM(MAX_TEXTURE_DIM)) u_div_u0 (
    .clk      (clk),
    .edge_val ({2'b0, src_left}),
    .dim      (texture_width),
    .quot     (u0)
  );

  sqvt_div #(.MAX_DIM(MAX_TEXTURE_DIM)) u_div_u1 (
    .clk      (clk),
    .edge_val (EDGE_W'(src_left) + EDGE_W'(src_width)),
    .dim      (texture_width),
    .quot     (u1)
  );

  sqvt_div #(.MAX_DIM(MAX_TEXTURE_DIM)) u_div_v0 (
    .clk      (clk),
    .edge_val ({2'b0, src_top}),
    .dim      (texture_height),
    .quot     (v0)
  );

  sqvt_div #(.MAX_DIM(MAX_TEXTURE_DIM)) u_div_v1 (
    .clk      (clk),
    .edge_val (EDGE_W'(src_top) + EDGE_W'(src_height)),
    .dim      (texture_height),
    .quot     (v1)
  );

  sqvt_dly #(.W(4 * UV_W), .DEPTH(ALIGN - DIV_LAT)) u_uv_dly (
    .clk (clk),
    .d   ({u0, u1, v0, v1}),
    .q   (uv_q)
  );

  always_comb begin
    {cin.lx0, cin.lx1, cin.ly0, cin.ly1, cin.px, cin.py} = geo_q;
    {cin.c, cin.s}                                       = trig_q;
    {cin.u0, cin.u1, cin.v0, cin.v1}                     = uv_q;
  end

  sqvt_corner u_corner (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (vsh[ALIGN-1]),
    .d            (cin),
    .vertex_valid (vertex_valid),
    .corner_index (corner_index),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .last_corner  (last_corner)
  );

endmodule

// File: hdl/sqvt_dly.sv
// Fixed-length register delay line used to align the unit outputs.
// Depends on nothing.
module sqvt_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

// File: hdl/sqvt_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q.28 from a binary angle.
// Depends on sqvt_pkg (gain, arctangent values, quadrant codes).
module sqvt_cordic import sqvt_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic [15:0]              angle,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  logic signed [CX_W-1:0] xs [STAGES+1];
  logic signed [CX_W-1:0] ys [STAGES+1];
  logic signed [31:0]     zs [STAGES+1];
  logic [1:0]             qs [STAGES+1];

  logic [31:0] a_full;
  logic [31:0] a_bias;
  logic [1:0]  quad;
  logic signed [CX_W-1:0] cr;
  logic signed [CX_W-1:0] sr;

  assign a_full = {angle, 16'b0};
  assign a_bias = a_full + 32'h2000_0000;
  assign quad   = a_bias[31:30];

  always_ff @(posedge clk) begin
    xs[0] <= CORDIC_GAIN;
    ys[0] <= '0;
    zs[0] <= $signed(a_full - {quad, 30'b0});
    qs[0] <= quad;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_val(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_val(i);
      end
      qs[i+1] <= qs[i];
    end
  end

  assign cr = (xs[STAGES] + 34'sd2) >>> 2;
  assign sr = (ys[STAGES] + 34'sd2) >>> 2;

  always_ff @(posedge clk) begin
    case (qs[STAGES])
      QUAD_0: begin
        cos_q <= cr[TRIG_W-1:0];
        sin_q <= sr[TRIG_W-1:0];
      end
      QUAD_1: begin
        cos_q <= -sr[TRIG_W-1:0];
        sin_q <= cr[TRIG_W-1:0];
      end
      QUAD_2: begin
        cos_q <= -cr[TRIG_W-1:0];
        sin_q <= -sr[TRIG_W-1:0];
      end
      default: begin
        cos_q <= sr[TRIG_W-1:0];
        sin_q <= -cr[TRIG_W-1:0];
      end
    endcase
  end

endmodule

// File: hdl/sqvt_div.sv
// Pipelined restoring divider: round(edge * 32768 / dim) saturated to 16 bits.
// One quotient bit per stage; depends on sqvt_pkg for widths.
module sqvt_div import sqvt_pkg::*; #(
  parameter int MAX_DIM = MAX_TEX_DIM_DEF
) (
  input  logic              clk,
  input  logic [EDGE_W-1:0] edge_val,
  input  logic [DIM_W-1:0]  dim,
  output logic [UV_W-1:0]   quot
);

  localparam int STEPS = DIV_LAT - 2;

  logic [31:0]     rem [STEPS+1];
  logic [15:0]     dd  [STEPS+1];
  logic [UV_W-1:0] qb  [STEPS+1];
  logic            sat [STEPS+1];

  logic [14:0] dimc;
  logic [15:0] dsor;
  logic [31:0] num;

  assign dimc = ({2'b0, dim} > 15'(MAX_DIM)) ? 15'(MAX_DIM) : {2'b0, dim};
  assign dsor = {dimc, 1'b0};
  assign num  = {2'b0, edge_val, 16'b0} + {17'b0, dimc};

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dd[0]  <= dsor;
    qb[0]  <= '0;
    sat[0] <= (dimc == '0) || (num >= {dsor, 16'b0});
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [31:0] trial;
    assign trial = {16'b0, dd[j]} << (STEPS - 1 - j);
    always_ff @(posedge clk) begin
      dd[j+1]  <= dd[j];
      sat[j+1] <= sat[j];
      if (rem[j] >= trial) begin
        rem[j+1] <= rem[j] - trial;
        qb[j+1]  <= qb[j] | (16'd1 << (STEPS - 1 - j));
      end else begin
        rem[j+1] <= rem[j];
        qb[j+1]  <= qb[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= sat[STEPS] ? 16'hFFFF : qb[STEPS];
  end

endmodule

// File: hdl/sqvt_corner.sv
// Corner sequencer: expands one aligned sprite word into four vertices,
// rotating, rounding, translating and saturating each. Depends on sqvt_pkg.
module sqvt_corner import sqvt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  sqvt_corner_in_t         d,
  output logic                    vertex_valid,
  output logic [1:0]              corner_index,
  output logic signed [POS_W-1:0] vertex_x,
  output logic signed [POS_W-1:0] vertex_y,
  output logic [UV_W-1:0]         tex_u,
  output logic [UV_W-1:0]         tex_v,
  output logic                    last_corner
);

  sqvt_corner_in_t h;
  logic       act;
  logic [1:0] k;

  logic                     m_v;
  logic [1:0]               m_k;
  logic signed [PROD_W-1:0] m_xc, m_ys, m_xs, m_yc;
  logic signed [POS_W-1:0]  m_px, m_py;
  logic [UV_W-1:0]          m_u, m_t;

  logic                    b_v;
  logic [1:0]              b_k;
  logic signed [SUM_W-1:0] b_rx, b_ry;
  logic signed [POS_W-1:0] b_px, b_py;
  logic [UV_W-1:0]         b_u, b_t;

  logic signed [LOC_W-1:0] lx, ly;
  logic signed [SUM_W-1:0] rxr, ryr;
  logic signed [38:0]      vx, vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      k   <= '0;
    end else if (in_valid) begin
      act <= 1'b1;
      k   <= '0;
    end else if (act) begin
      k <= k + 2'd1;
      if (k == QUAD_3) begin
        act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      h <= d;
    end
  end

  assign lx = k[0] ? h.lx1 : h.lx0;
  assign ly = k[1] ? h.ly1 : h.ly0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      b_v <= 1'b0;
      vertex_valid <= 1'b0;
    end else begin
      m_v <= act;
      b_v <= m_v;
      vertex_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    m_k  <= k;
    m_xc <= PROD_W'(lx) * PROD_W'(h.c);
    m_ys <= PROD_W'(ly) * PROD_W'(h.s);
    m_xs <= PROD_W'(lx) * PROD_W'(h.s);
    m_yc <= PROD_W'(ly) * PROD_W'(h.c);
    m_px <= h.px;
    m_py <= h.py;
    m_u  <= k[0] ? h.u1 : h.u0;
    m_t  <= k[1] ? h.v1 : h.v0;

    b_k  <= m_k;
    b_rx <= SUM_W'(m_xc) - SUM_W'(m_ys);
    b_ry <= SUM_W'(m_xs) + SUM_W'(m_yc);
    b_px <= m_px;
    b_py <= m_py;
    b_u  <= m_u;
    b_t  <= m_t;
  end

  assign rxr = b_rx + (SUM_W'(1) <<< 31);
  assign ryr = b_ry + (SUM_W'(1) <<< 31);
  assign vx  = 39'(rxr >>> 32) + 39'(b_px);
  assign vy  = 39'(ryr >>> 32) + 39'(b_py);

  always_ff @(posedge clk) begin
    corner_index <= b_k;
    vertex_x     <= sat24(vx);
    vertex_y     <= sat24(vy);
    tex_u        <= b_u;
    tex_v        <= b_t;
    last_corner  <= b_v && (b_k == QUAD_3);
  end

endmodule

// File: hdl/sqvt_checker.sv
// Port-level checks for the sprite quad vertex transform, bound to the top level.
// Depends on sqvt_pkg for the corner codes.
module sqvt_checker import sqvt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       vertex_valid,
  input logic [1:0] corner_index,
  input logic       last_corner
);

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a request word was taken");

  a_last_is_fourth: assert property (@(posedge clk) disable iff (rst)
    last_corner |-> vertex_valid && corner_index == QUAD_3)
    else $error("last_corner outside the fourth vertex");

  a_tl_then_tr: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && corner_index == QUAD_0 |=> vertex_valid && corner_index == QUAD_1)
    else $error("top-right vertex did not follow top-left");

  a_tr_then_bl: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && corner_index == QUAD_1 |=> vertex_valid && corner_index == QUAD_2)
    else $error("bottom-left vertex did not follow top-right");

endmodule

bind sprite_quad_vertex_transform sqvt_checker u_sqvt_checker (.*);
